### sv/sibs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibs_pkg
// Shared types and constants of the serial bus bridge sequencer.
// ----------------------------------------------------------------------------
package sibs_pkg;

  localparam int IDLE_BITS_DEFAULT = 16;
  localparam int TIMEOUT_W         = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CHAR_START = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_STOP  = 8'h50;  // 'P'
  localparam logic [7:0] CHAR_ERROR = 8'h45;  // 'E'

  // sticky error flag positions
  localparam int ERR_ADDR_NACK = 0;
  localparam int ERR_DATA_NACK = 1;
  localparam int ERR_TIMEOUT   = 2;

  typedef enum logic [1:0] {
    OP_HOST    = 2'd0,
    OP_WR_DONE = 2'd1,
    OP_RD_DONE = 2'd2,
    OP_TICK    = 2'd3
  } sibs_opcode_t;

  typedef enum logic [2:0] {
    ACT_RESP  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4
  } sibs_action_t;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ADDR = 2'd1,
    PEND_DATA = 2'd2,
    PEND_READ = 2'd3
  } sibs_pend_t;

  typedef struct packed {
    sibs_opcode_t opcode;
    logic [7:0]   host_byte;
    logic         bus_nack;
    logic         bus_timeout;
    logic [7:0]   bus_data;
  } sibs_item_t;

  typedef struct packed {
    sibs_action_t action;
    logic [7:0]   out_byte;
    logic         nack_after_read;
    logic         last_of_run;
  } sibs_result_t;

  typedef struct packed {
    logic [1:0]   count;
    sibs_result_t r0;
    sibs_result_t r1;
  } sibs_push_t;

endpackage

### sv/sibs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibs_step
// Transaction state and its registered update for each request; emits up to two
// results per request.
// ----------------------------------------------------------------------------
module sibs_step
  import sibs_pkg::*;
#(
  parameter int IDLE_COUNTER_BITS = IDLE_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  sibs_item_t           item,
  input  logic [TIMEOUT_W-1:0] timeout_ms,
  output sibs_push_t           push
);

  localparam int CMP_W = (IDLE_COUNTER_BITS > TIMEOUT_W) ? IDLE_COUNTER_BITS : TIMEOUT_W;

  logic                         in_trans, in_trans_next;
  logic                         addr_taken, addr_taken_next;
  logic                         len_taken, len_taken_next;
  logic                         read_dir, read_dir_next;
  logic [7:0]                   remaining, remaining_next;
  logic [2:0]                   err, err_next;
  sibs_pend_t                   pend, pend_next;
  logic [IDLE_COUNTER_BITS-1:0] idle_ms, idle_ms_next;

  logic [7:0]   err_byte;
  logic [7:0]   rem_dec;
  logic [7:0]   b;
  sibs_result_t res0, res1;
  logic [1:0]   n;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_trans   <= 1'b0;
      addr_taken <= 1'b0;
      len_taken  <= 1'b0;
      read_dir   <= 1'b0;
      remaining  <= '0;
      err        <= '0;
      pend       <= PEND_NONE;
      idle_ms    <= '0;
    end else begin
      in_trans   <= in_trans_next;
      addr_taken <= addr_taken_next;
      len_taken  <= len_taken_next;
      read_dir   <= read_dir_next;
      remaining  <= remaining_next;
      err        <= err_next;
      pend       <= pend_next;
      idle_ms    <= idle_ms_next;
    end
  end

  assign err_byte = {4'b0000, err[ERR_TIMEOUT], 1'b0, err[ERR_DATA_NACK], err[ERR_ADDR_NACK]};
  assign rem_dec  = remaining - 8'd1;
  assign b        = item.host_byte;

  always_comb begin
    in_trans_next   = in_trans;
    addr_taken_next = addr_taken;
    len_taken_next  = len_taken;
    read_dir_next   = read_dir;
    remaining_next  = remaining;
    err_next        = err;
    pend_next       = pend;
    idle_ms_next    = idle_ms;
    res0            = '{ACT_RESP, 8'h00, 1'b0, 1'b0};
    res1            = '{ACT_RESP, 8'h00, 1'b0, 1'b0};
    n               = 2'd0;

    if (item_valid) begin
      case (item.opcode)
        OP_HOST: begin
          // drop host bytes while anything is pending
          if (pend == PEND_NONE) begin
            idle_ms_next = '0;
            if (!in_trans) begin
              if (b == CHAR_START) begin
                res0            = '{ACT_START, 8'h00, 1'b0, 1'b0};
                n               = 2'd1;
                in_trans_next   = 1'b1;
                addr_taken_next = 1'b0;
                len_taken_next  = 1'b0;
              end else if (b == CHAR_ERROR) begin
                res0     = '{ACT_RESP, err_byte, 1'b0, 1'b0};
                n        = 2'd1;
                err_next = '0;
              end
            end else if (!addr_taken) begin
              read_dir_next   = b[0];
              addr_taken_next = 1'b1;
              res0            = '{ACT_WRITE, b, 1'b0, 1'b0};
              n               = 2'd1;
              pend_next       = PEND_ADDR;
            end else if (!len_taken) begin
              remaining_next = b;
              len_taken_next = 1'b1;
              if (read_dir && b != 8'd0) begin
                res0      = '{ACT_READ, 8'h00, (b == 8'd1), 1'b0};
                n         = 2'd1;
                pend_next = PEND_READ;
              end
            end else if (!read_dir && remaining != 8'd0) begin
              res0           = '{ACT_WRITE, b, 1'b0, 1'b0};
              n              = 2'd1;
              remaining_next = rem_dec;
              pend_next      = PEND_DATA;
            end else if (b == CHAR_START) begin
              res0            = '{ACT_START, 8'h00, 1'b0, 1'b0};
              n               = 2'd1;
              addr_taken_next = 1'b0;
              len_taken_next  = 1'b0;
            end else if (b == CHAR_STOP) begin
              res0          = '{ACT_STOP, 8'h00, 1'b0, 1'b0};
              n             = 2'd1;
              in_trans_next = 1'b0;
            end else if (b == CHAR_ERROR) begin
              res0     = '{ACT_RESP, err_byte, 1'b0, 1'b0};
              n        = 2'd1;
              err_next = '0;
            end
          end
        end
        OP_WR_DONE: begin
          if (pend == PEND_ADDR || pend == PEND_DATA) begin
            // timeout wins over NACK
            if (item.bus_timeout) begin
              err_next[ERR_TIMEOUT] = 1'b1;
            end else if (item.bus_nack) begin
              if (pend == PEND_ADDR) err_next[ERR_ADDR_NACK] = 1'b1;
              else err_next[ERR_DATA_NACK] = 1'b1;
            end
            pend_next = PEND_NONE;
          end
        end
        OP_RD_DONE: begin
          if (pend == PEND_READ) begin
            res0 = '{ACT_RESP, item.bus_timeout ? 8'h00 : item.bus_data, 1'b0, 1'b0};
            if (item.bus_timeout) err_next[ERR_TIMEOUT] = 1'b1;
            n              = 2'd1;
            remaining_next = rem_dec;
            if (rem_dec != 8'd0) begin
              res1 = '{ACT_READ, 8'h00, (rem_dec == 8'd1), 1'b0};
              n    = 2'd2;
            end else begin
              pend_next = PEND_NONE;
            end
          end
        end
        OP_TICK: begin
          if (idle_ms != {IDLE_COUNTER_BITS{1'b1}}) idle_ms_next = idle_ms + 1'b1;
          if (pend == PEND_NONE && in_trans && timeout_ms != '0 &&
              CMP_W'(idle_ms_next) > CMP_W'(timeout_ms)) begin
            res0          = '{ACT_STOP, 8'h00, 1'b0, 1'b0};
            n             = 2'd1;
            in_trans_next = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (n == 2'd1) res0.last_of_run = 1'b1;
    if (n == 2'd2) res1.last_of_run = 1'b1;
    push = '{n, res0, res1};
  end

endmodule

### sv/sibs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibs_fifo
// Result queue: takes up to two results per cycle, drains one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sibs_fifo
  import sibs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  sibs_push_t   push,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output sibs_result_t out_data
);

  sibs_result_t       mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, wr_ptr_next;
  logic [FIFO_AW-1:0] rd_ptr, rd_ptr_next;
  logic [FIFO_AW:0]   count, count_next;
  logic               pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign room      = count <= (FIFO_AW+1)'(FIFO_DEPTH - 2);
  assign out_data  = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_AW'(push.count);
    rd_ptr_next = rd_ptr + FIFO_AW'(pop);
    count_next  = count + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.r0;
    if (push.count == 2'd2) mem[wr_ptr + FIFO_AW'(1)] <= push.r1;
  end

endmodule

### sv/serial_i2c_bridge_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_i2c_bridge_sequencer
// Host byte command stream to bus-master operation sequencer.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser holds the request kind (host
// byte, bus write done, bus read done, millisecond tick), tdata its payload.
// Results leave on m_axis: tuser is the action (host response, start, stop,
// write, read), tdata the byte and the read NACK flag, tlast marks the final
// result of one request. A request makes zero, one or two results.
// The cfg channel writes the idle timeout in milliseconds; it is always ready.
//
// A request is registered at acceptance; once the queue has room it updates the
// transaction state and pushes its results into a four-entry queue at the same
// edge, and the queue head drives m_axis. One request per cycle is taken while
// the queue holds at most two results; the queue drain of one result per cycle
// sets the sustained rate when requests make two results.
// When the receiver stalls the queue fills and s_axis_tready drops; nothing
// is lost. Reset clears the transaction state, the error flags, the idle
// count and the queue, and loads the timeout with 500.
// ----------------------------------------------------------------------------
module serial_i2c_bridge_sequencer
  import sibs_pkg::*;
#(
  parameter int IDLE_COUNTER_BITS = IDLE_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] host_byte, [8] bus_nack, [9] bus_timeout, [17:10] bus_data
  input  logic [23:0]          s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] out_byte, [8] nack_after_read
  output logic [15:0]          m_axis_tdata,
  // [2:0] action
  output logic [2:0]           m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TIMEOUT_W-1:0] cfg_data
);

  logic                 in_valid, in_valid_next;
  sibs_item_t           in_item;
  logic [TIMEOUT_W-1:0] timeout_ms;
  logic                 room;
  logic                 consume;
  sibs_push_t           push;
  sibs_result_t         out_res;

  assign cfg_ready     = 1'b1;
  assign consume       = in_valid && room;
  assign s_axis_tready = !in_valid || room;
  assign in_valid_next = (s_axis_tvalid && s_axis_tready) || (in_valid && !consume);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      timeout_ms <= TIMEOUT_RESET;
    end else begin
      in_valid <= in_valid_next;
      if (cfg_valid && cfg_ready) timeout_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= '{sibs_opcode_t'(s_axis_tuser), s_axis_tdata[7:0], s_axis_tdata[8],
                   s_axis_tdata[9], s_axis_tdata[17:10]};
    end
  end

  sibs_step #(
    .IDLE_COUNTER_BITS(IDLE_COUNTER_BITS)
  ) u_step (
    .clk       (clk),
    .rst       (rst),
    .item_valid(consume),
    .item      (in_item),
    .timeout_ms(timeout_ms),
    .push      (push)
  );

  sibs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_res)
  );

  assign m_axis_tdata = {7'b0000000, out_res.nack_after_read, out_res.out_byte};
  assign m_axis_tuser = out_res.action;
  assign m_axis_tlast = out_res.last_of_run;

endmodule

### sv/sibs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sibs_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sibs_checker
  import sibs_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // read NACK flag only on bus reads
  a_nack_on_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ACT_READ |-> !m_axis_tdata[8])
    else $error("nack flag on non-read action");

  // start, stop and read carry no byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ACT_START || m_axis_tuser == ACT_STOP ||
                      m_axis_tuser == ACT_READ) |-> m_axis_tdata[7:0] == 8'h00)
    else $error("byte on start, stop or read");

  // a bus read always closes the results of its request
  a_read_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ACT_READ |-> m_axis_tlast)
    else $error("bus read not last result of its request");

endmodule

bind serial_i2c_bridge_sequencer sibs_checker u_sibs_checker (.*);
